FILE: rtl/lbf_pkg.sv
package lbf_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int TARGET_BITS    = 10;
   localparam int STEP_BITS      = 4;
   localparam int PHASE_BITS     = 16;
   localparam int PHASE_CNT_BITS = 17;
   localparam int STEP_MS_BITS   = 10;
   localparam int NUM_CHANNELS   = 4;
   localparam int CH_WHITE       = 3;

   localparam logic [PHASE_BITS-1:0]   PHASE_MS_RESET = 16'd3000;
   localparam logic [STEP_MS_BITS-1:0] STEP_MS_RESET  = 10'd30;

   // Reciprocal of the step divisor (100) scaled by 2^17, exact for 10-bit targets.
   localparam int                   RECIP_SHIFT = 17;
   localparam logic [10:0]          RECIP_100   = 11'd1311;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_RED_TARGET   = 3'd0,
      REG_GREEN_TARGET = 3'd1,
      REG_BLUE_TARGET  = 3'd2,
      REG_WHITE_TARGET = 3'd3,
      REG_WHITE_MODE   = 3'd4,
      REG_PHASE_MS     = 3'd5,
      REG_STEP_MS      = 3'd6,
      REG_UNUSED       = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic                    white_mode;
      logic [PHASE_BITS-1:0]   phase_ms;
      logic [STEP_MS_BITS-1:0] step_ms;
   } timing_cfg_type;

   function automatic logic [STEP_BITS-1:0] step_of(input logic [TARGET_BITS-1:0] target);
      logic [TARGET_BITS+10:0] prod;
      prod = (TARGET_BITS+11)'(target) * (TARGET_BITS+11)'(RECIP_100);
      return STEP_BITS'(prod[TARGET_BITS+10:RECIP_SHIFT]) + STEP_BITS'(1);
   endfunction

endpackage

FILE: rtl/lbf_interfaces.sv
interface lbf_req_if;
   logic valid;
   logic ready;
   logic advance;

   modport source (output valid, output advance, input ready);
   modport sink   (input valid, input advance, output ready);
endinterface

interface lbf_rsp_if #(
   parameter int LEVEL_BITS = 10
);
   logic                  valid;
   logic                  ready;
   logic [LEVEL_BITS-1:0] red_level;
   logic [LEVEL_BITS-1:0] green_level;
   logic [LEVEL_BITS-1:0] blue_level;
   logic [LEVEL_BITS-1:0] white_level;
   logic                  bright_phase;

   modport source (output valid, output red_level, output green_level, output blue_level,
                   output white_level, output bright_phase, input ready);
   modport sink   (input valid, input red_level, input green_level, input blue_level,
                   input white_level, input bright_phase, output ready);
endinterface

interface lbf_csr_if;
   logic                                valid;
   logic                                ready;
   logic [lbf_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [lbf_pkg::CSR_DATA_BITS-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/lbf_csr.sv
module lbf_csr #(
   parameter int LEVEL_BITS = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   lbf_csr_if.sink                        csr_chan,
   output logic [LEVEL_BITS-1:0]          target_out [lbf_pkg::NUM_CHANNELS],
   output logic [LEVEL_BITS-1:0]          step_out   [lbf_pkg::NUM_CHANNELS],
   output lbf_pkg::timing_cfg_type        timing_out
);

   localparam int TGT_BITS = (LEVEL_BITS < lbf_pkg::TARGET_BITS) ? LEVEL_BITS
                                                                 : lbf_pkg::TARGET_BITS;

   logic [LEVEL_BITS-1:0]              target_ff [lbf_pkg::NUM_CHANNELS];
   logic [LEVEL_BITS-1:0]              step_ff   [lbf_pkg::NUM_CHANNELS];
   lbf_pkg::timing_cfg_type            timing_ff;
   logic                               write;
   logic [lbf_pkg::TARGET_BITS-1:0]    target_in;
   logic [lbf_pkg::STEP_BITS-1:0]      step_in;
   lbf_pkg::reg_index_type             index;

   assign csr_chan.ready = 1'b1;
   assign write          = csr_chan.valid;
   assign index          = lbf_pkg::reg_index_type'(csr_chan.index);
   assign target_in      = lbf_pkg::TARGET_BITS'(csr_chan.data[TGT_BITS-1:0]);
   assign step_in        = lbf_pkg::step_of(target_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < lbf_pkg::NUM_CHANNELS; c++) begin
            target_ff[c] <= '0;
            step_ff[c]   <= LEVEL_BITS'(1);
         end
         timing_ff.white_mode <= 1'b0;
         timing_ff.phase_ms   <= lbf_pkg::PHASE_MS_RESET;
         timing_ff.step_ms    <= lbf_pkg::STEP_MS_RESET;
      end else if (write) begin
         unique case (index)
            lbf_pkg::REG_RED_TARGET: begin
               target_ff[0] <= LEVEL_BITS'(target_in);
               step_ff[0]   <= LEVEL_BITS'(step_in);
            end
            lbf_pkg::REG_GREEN_TARGET: begin
               target_ff[1] <= LEVEL_BITS'(target_in);
               step_ff[1]   <= LEVEL_BITS'(step_in);
            end
            lbf_pkg::REG_BLUE_TARGET: begin
               target_ff[2] <= LEVEL_BITS'(target_in);
               step_ff[2]   <= LEVEL_BITS'(step_in);
            end
            lbf_pkg::REG_WHITE_TARGET: begin
               target_ff[lbf_pkg::CH_WHITE] <= LEVEL_BITS'(target_in);
               step_ff[lbf_pkg::CH_WHITE]   <= LEVEL_BITS'(step_in);
            end
            lbf_pkg::REG_WHITE_MODE: begin
               timing_ff.white_mode <= csr_chan.data[0];
            end
            lbf_pkg::REG_PHASE_MS: begin
               timing_ff.phase_ms <= csr_chan.data[lbf_pkg::PHASE_BITS-1:0];
            end
            lbf_pkg::REG_STEP_MS: begin
               timing_ff.step_ms <= csr_chan.data[lbf_pkg::STEP_MS_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign target_out = target_ff;
   assign step_out   = step_ff;
   assign timing_out = timing_ff;

endmodule

FILE: rtl/lbf_core.sv
module lbf_core #(
   parameter int LEVEL_BITS = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  logic                      advance,
   input  logic [LEVEL_BITS-1:0]     target  [lbf_pkg::NUM_CHANNELS],
   input  logic [LEVEL_BITS-1:0]     step    [lbf_pkg::NUM_CHANNELS],
   input  lbf_pkg::timing_cfg_type   timing,
   output logic [LEVEL_BITS-1:0]     level_out [lbf_pkg::NUM_CHANNELS],
   output logic                      bright_out
);

   logic [lbf_pkg::PHASE_CNT_BITS-1:0] phase_elapsed_ff, phase_elapsed_in;
   logic [lbf_pkg::STEP_MS_BITS-1:0]   step_elapsed_ff, step_elapsed_in;
   logic                               reload_pending_ff, reload_pending_in;
   logic [LEVEL_BITS-1:0]              level_ff [lbf_pkg::NUM_CHANNELS];
   logic [LEVEL_BITS-1:0]              level_in [lbf_pkg::NUM_CHANNELS];

   logic [lbf_pkg::PHASE_BITS-1:0]     plen;
   logic                               bright;
   logic                               load_dark;
   logic                               load_bright;
   logic                               do_step;
   logic                               tick;
   logic [lbf_pkg::PHASE_CNT_BITS:0]   phase_inc;

   assign tick        = take && advance;
   assign plen        = (timing.phase_ms == '0) ? lbf_pkg::PHASE_BITS'(1) : timing.phase_ms;
   assign bright      = phase_elapsed_ff >= lbf_pkg::PHASE_CNT_BITS'(plen);
   assign load_dark   = !bright && reload_pending_ff;
   assign load_bright = bright && !reload_pending_ff;
   assign do_step     = step_elapsed_ff >= timing.step_ms;

   for (genvar c = 0; c < lbf_pkg::NUM_CHANNELS; c++) begin : g_chan
      logic                  active;
      logic [LEVEL_BITS-1:0] base;
      logic [LEVEL_BITS:0]   up_sum;
      logic [LEVEL_BITS-1:0] up;
      logic [LEVEL_BITS-1:0] down;

      assign active = timing.white_mode ? (c == lbf_pkg::CH_WHITE) : (c != lbf_pkg::CH_WHITE);

      always_comb begin
         base = level_ff[c];
         if (active && load_dark) begin
            base = target[c];
         end else if (active && load_bright) begin
            base = '0;
         end
         up_sum = {1'b0, base} + {1'b0, step[c]};
         up     = (up_sum > {1'b0, target[c]}) ? target[c] : up_sum[LEVEL_BITS-1:0];
         down   = (base >= step[c]) ? (base - step[c]) : '0;
         if (active && do_step) begin
            level_in[c] = bright ? up : down;
         end else begin
            level_in[c] = base;
         end
      end
   end

   always_comb begin
      reload_pending_in = reload_pending_ff;
      if (load_dark) begin
         reload_pending_in = 1'b0;
      end else if (load_bright) begin
         reload_pending_in = 1'b1;
      end
      step_elapsed_in = do_step ? '0 : step_elapsed_ff + lbf_pkg::STEP_MS_BITS'(1);
      phase_inc       = {1'b0, phase_elapsed_ff} + (lbf_pkg::PHASE_CNT_BITS+1)'(1);
      if (phase_inc >= {1'b0, plen, 1'b0}) begin
         phase_elapsed_in = '0;
      end else begin
         phase_elapsed_in = phase_inc[lbf_pkg::PHASE_CNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_elapsed_ff  <= '0;
         step_elapsed_ff   <= '0;
         reload_pending_ff <= 1'b1;
         for (int c = 0; c < lbf_pkg::NUM_CHANNELS; c++) begin
            level_ff[c] <= '0;
         end
      end else if (tick) begin
         phase_elapsed_ff  <= phase_elapsed_in;
         step_elapsed_ff   <= step_elapsed_in;
         reload_pending_ff <= reload_pending_in;
         level_ff          <= level_in;
      end
   end

   assign level_out  = advance ? level_in : level_ff;
   assign bright_out = bright;

endmodule

FILE: rtl/led_breathing_fader.sv
// Channel   Direction  Payload
// req_chan  in         advance
// rsp_chan  out        red_level, green_level, blue_level, white_level, bright_phase
// csr_chan  in         index, data (always ready)
//
// Each request transfer yields one response in the next cycle, from the output register.
// A new request is taken every cycle while the output register is empty or being drained.
// A stalled response holds the output register and blocks further requests.
// Reset is synchronous and restores the register defaults and the start of the dark phase.
module led_breathing_fader #(
   parameter int LEVEL_BITS = 10
) (
   input  logic       clock,
   input  logic       reset,
   lbf_req_if.sink    req_chan,
   lbf_rsp_if.source  rsp_chan,
   lbf_csr_if.sink    csr_chan
);

   logic [LEVEL_BITS-1:0]     target    [lbf_pkg::NUM_CHANNELS];
   logic [LEVEL_BITS-1:0]     step      [lbf_pkg::NUM_CHANNELS];
   logic [LEVEL_BITS-1:0]     level     [lbf_pkg::NUM_CHANNELS];
   lbf_pkg::timing_cfg_type   timing;
   logic                      bright;
   logic                      take;

   logic                      rsp_valid_ff;
   logic [LEVEL_BITS-1:0]     level_ff  [lbf_pkg::NUM_CHANNELS];
   logic                      bright_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign take           = req_chan.valid && req_chan.ready;

   lbf_csr #(.LEVEL_BITS(LEVEL_BITS)) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_chan   (csr_chan),
      .target_out (target),
      .step_out   (step),
      .timing_out (timing)
   );

   lbf_core #(.LEVEL_BITS(LEVEL_BITS)) u_core (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .advance    (req_chan.advance),
      .target     (target),
      .step       (step),
      .timing     (timing),
      .level_out  (level),
      .bright_out (bright)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         level_ff  <= level;
         bright_ff <= bright;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.red_level    = level_ff[0];
   assign rsp_chan.green_level  = level_ff[1];
   assign rsp_chan.blue_level   = level_ff[2];
   assign rsp_chan.white_level  = level_ff[lbf_pkg::CH_WHITE];
   assign rsp_chan.bright_phase = bright_ff;

endmodule

FILE: rtl/lbf_checker.sv
module lbf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic csr_ready
);

   // A response waiting on the sink must stay offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response must block new requests.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

   // Every request transfer produces a response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("request transfer without response");

   // No response appears without a request transfer or a held response.
   assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready) && !(rsp_valid && !rsp_ready) |=> !rsp_valid)
      else $error("response without request");

   // The configuration port never stalls.
   assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("configuration port not ready");

endmodule

bind led_breathing_fader lbf_checker u_lbf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .csr_ready (csr_chan.ready)
);
